### rtl/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg
// shared types and constants of the contiguous block allocator
// ----------------------------------------------------------------------------
package cba_pkg;

  // payload widths
  localparam int SIZE_W    = 8;
  localparam int OWNER_W   = 8;
  localparam int IDX_OUT_W = 4;
  localparam int STATUS_W  = 2;
  localparam int RSV_W     = 4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 2'd2;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_RESERVED_BLOCKS = 1'b0;
  localparam logic [RSV_W-1:0] RSV_RESET = 4'd8;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic write;
    logic push;
  } cba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic reject;
    logic found;
    logic exhausted;
    logic wr_last;
  } cba_sts_t;

endpackage

### rtl/cba_if.sv
// ----------------------------------------------------------------------------
// cba_req_if / cba_rsp_if
// valid/ready channels for allocation requests and results
// ----------------------------------------------------------------------------
interface cba_req_if;
  import cba_pkg::*;
  logic               valid;
  logic               ready;
  logic [SIZE_W-1:0]  request_size;
  logic [OWNER_W-1:0] owner_id;
  modport source (output valid, output request_size, output owner_id, input ready);
  modport sink   (input valid, input request_size, input owner_id, output ready);
endinterface

interface cba_rsp_if;
  import cba_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [IDX_OUT_W-1:0] first_block;
  logic [IDX_OUT_W-1:0] last_block;
  modport source (output valid, output status, output first_block, output last_block,
                  input ready);
  modport sink   (input valid, input status, input first_block, input last_block,
                  output ready);
endinterface

### rtl/cba_ctrl.sv
// ----------------------------------------------------------------------------
// cba_ctrl
// sequencer of the allocator: load, scan, claim, respond
// ----------------------------------------------------------------------------
module cba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output cba_pkg::cba_cmd_t cmd,
  input  cba_pkg::cba_sts_t sts
);
  import cba_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = sts.reject ? S_RESP : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          state_next = S_WRITE;
        end else if (sts.exhausted) begin
          state_next = S_RESP;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        if (sts.wr_last) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        // result register free or being emptied this cycle
        if (!out_valid || out_ready) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.push) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("controller stayed idle after taking an item");

  a_push_fills_output: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> out_valid)
    else $error("result push did not raise output valid");

  a_valid_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_RESP)
    else $error("output valid rose outside the respond state");

endmodule

### rtl/cba_datapath.sv
// ----------------------------------------------------------------------------
// cba_datapath
// owner map, first-fit scan counters and result registers
// ----------------------------------------------------------------------------
module cba_datapath #(
  parameter int BLOCK_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cba_pkg::cba_cmd_t             cmd,
  output cba_pkg::cba_sts_t             sts,
  input  logic [cba_pkg::RSV_W-1:0]     reserved_blocks,
  input  logic [cba_pkg::SIZE_W-1:0]    request_size,
  input  logic [cba_pkg::OWNER_W-1:0]   owner_id,
  output logic [cba_pkg::STATUS_W-1:0]  status,
  output logic [cba_pkg::IDX_OUT_W-1:0] first_block,
  output logic [cba_pkg::IDX_OUT_W-1:0] last_block
);
  import cba_pkg::*;

  localparam int ADDR_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int CNT_W  = $clog2(BLOCK_COUNT + 1);
  localparam int EXT_W  = (ADDR_W > IDX_OUT_W) ? ADDR_W : IDX_OUT_W;
  localparam int CMP_A  = (CNT_W > RSV_W) ? CNT_W : RSV_W;
  localparam int CMP_W  = (CMP_A > SIZE_W) ? CMP_A : SIZE_W;
  localparam logic [CNT_W-1:0] BC_C   = CNT_W'(BLOCK_COUNT);
  localparam logic [CMP_W-1:0] BC_CMP = CMP_W'(BLOCK_COUNT);

  // owner map: memory plus per-block written flags
  logic [OWNER_W-1:0]     owner_mem [BLOCK_COUNT];
  logic [BLOCK_COUNT-1:0] owner_vld;

  logic [SIZE_W-1:0]    req_size;
  logic [OWNER_W-1:0]   req_owner;
  logic [CNT_W-1:0]     rd_addr;
  logic                 chk_v;
  logic [ADDR_W-1:0]    chk_idx;
  logic [OWNER_W-1:0]   mem_q;
  logic                 vld_q;
  logic [SIZE_W-1:0]    run;
  logic [ADDR_W-1:0]    start;
  logic [ADDR_W-1:0]    wr_ptr;
  logic [SIZE_W-1:0]    wr_left;
  logic [STATUS_W-1:0]  res_status;
  logic [IDX_OUT_W-1:0] res_first;
  logic [IDX_OUT_W-1:0] res_last;

  logic [CMP_W-1:0]  rsv_ext;
  logic [CMP_W-1:0]  size_ext;
  logic [CMP_W-1:0]  unreserved;
  logic              too_small;
  logic              too_big;
  logic              rd_go;
  logic              chk_go;
  logic              blk_free;
  logic [SIZE_W-1:0] run_next;
  logic [ADDR_W-1:0] start_sel;
  logic [EXT_W-1:0]  first_ext;
  logic [EXT_W-1:0]  last_ext;

  // request checks against the unreserved area
  assign rsv_ext    = CMP_W'(reserved_blocks);
  assign size_ext   = CMP_W'(request_size);
  assign unreserved = (rsv_ext < BC_CMP) ? (BC_CMP - rsv_ext) : '0;
  assign too_small  = (request_size == '0);
  assign too_big    = (size_ext > unreserved);

  // scan: read issued one cycle, checked the next
  assign rd_go     = cmd.scan && (rd_addr < BC_C);
  assign chk_go    = cmd.scan && chk_v;
  assign blk_free  = !vld_q || (mem_q == '0);
  assign run_next  = run + 1'b1;
  assign start_sel = (run == '0) ? chk_idx : start;
  assign first_ext = EXT_W'(start_sel);
  assign last_ext  = EXT_W'(chk_idx);

  assign sts.reject    = too_small || too_big;
  assign sts.found     = chk_go && blk_free && (run_next == req_size);
  assign sts.exhausted = cmd.scan && !chk_v && (rd_addr >= BC_C);
  assign sts.wr_last   = (wr_left == SIZE_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      owner_mem[wr_ptr] <= req_owner;
    end
    if (rd_go) begin
      mem_q <= owner_mem[rd_addr[ADDR_W-1:0]];
      vld_q <= owner_vld[rd_addr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owner_vld <= '0;
    end else if (cmd.write) begin
      owner_vld[wr_ptr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_v <= 1'b0;
    end else if (cmd.load) begin
      chk_v <= 1'b0;
    end else if (cmd.scan) begin
      chk_v <= rd_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_size   <= request_size;
      req_owner  <= owner_id;
      rd_addr    <= CNT_W'(reserved_blocks);
      run        <= '0;
      res_status <= too_small ? ST_TOO_SMALL : ST_NO_ROOM;
      res_first  <= '0;
      res_last   <= '0;
    end
    if (rd_go) begin
      rd_addr <= rd_addr + 1'b1;
      chk_idx <= rd_addr[ADDR_W-1:0];
    end
    if (chk_go) begin
      if (blk_free) begin
        run   <= run_next;
        start <= start_sel;
      end else begin
        run <= '0;
      end
    end
    if (sts.found) begin
      wr_ptr     <= start_sel;
      wr_left    <= req_size;
      res_status <= ST_OK;
      res_first  <= first_ext[IDX_OUT_W-1:0];
      res_last   <= last_ext[IDX_OUT_W-1:0];
    end
    if (cmd.write) begin
      wr_ptr  <= wr_ptr + 1'b1;
      wr_left <= wr_left - 1'b1;
    end
    if (cmd.push) begin
      status      <= res_status;
      first_block <= res_first;
      last_block  <= res_last;
    end
  end

  a_write_has_work: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> wr_left != '0)
    else $error("claim step with no blocks left to write");

  a_check_in_range: assert property (@(posedge clk) disable iff (rst)
    chk_go |-> CNT_W'(chk_idx) < BC_C)
    else $error("checked block index beyond the map");

  a_found_then_write: assert property (@(posedge clk) disable iff (rst)
    sts.found |=> cmd.write)
    else $error("found run not followed by a claim step");

endmodule

### rtl/contiguous_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// contiguous_block_allocator_unit
// first-fit allocator of contiguous runs of blocks
// ----------------------------------------------------------------------------
// Each request names a size in blocks and an owner id. The unit keeps an owner
// map of BLOCK_COUNT entries, all free after reset, and looks upward from the
// first block above the reserved area for the first run of free blocks as
// long as the request. That run is written with the owner id and the result
// gives status ok with its first and last block (low four bits). A zero size
// gives "too small"; a size beyond the unreserved blocks, or no fitting run,
// gives "no room" and the map stays as it was. An owner id of zero is written
// like any other, so those blocks remain free. Items are handled one at a
// time: the request is loaded, the blocks are looked at one by one through a
// registered read of the single read port of the owner map, the blocks are
// claimed one by one, and the result is handed over; a request rejected at
// once goes from load straight to the result. A new item is taken while the
// previous result still waits in the output register. The user must write
// the reserved_blocks register (byte address 0, reset 8) over the APB-style
// port only while the unit is idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module contiguous_block_allocator_unit #(
  parameter int BLOCK_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cba_pkg::PADDR_W-1:0]   paddr,
  input  logic [cba_pkg::PDATA_W-1:0]   pwdata,
  output logic [cba_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // request and result channels
  cba_req_if.sink                       req,
  cba_rsp_if.source                     rsp
);
  import cba_pkg::*;

  logic [RSV_W-1:0] reserved_blocks;
  logic             cfg_wr;
  cba_cmd_t         cmd;
  cba_sts_t         sts;

  // register file: a single register, word index from paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_blocks <= RSV_RESET;
    end else if (cfg_wr && (paddr[2] == REG_RESERVED_BLOCKS)) begin
      reserved_blocks <= pwdata[RSV_W-1:0];
    end
  end

  // read back, unmapped words read as zero
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RESERVED_BLOCKS) begin
      prdata = PDATA_W'(reserved_blocks);
    end
  end

  // sequencer: owns the handshakes and the output valid
  cba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // owner map, scan and result payload
  cba_datapath #(
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .reserved_blocks (reserved_blocks),
    .request_size    (req.request_size),
    .owner_id        (req.owner_id),
    .status          (rsp.status),
    .first_block     (rsp.first_block),
    .last_block      (rsp.last_block)
  );

endmodule
